>>> rtl/core/rspu_pkg.sv
package rspu_pkg;

	localparam int COORD_W      = 9;
	localparam int AMOUNT_W     = 32;
	localparam int SIZE_W       = 9;
	localparam int SUM_W        = 32;
	localparam int GRID_DEFAULT = 256;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
	localparam logic              KIND_ADD   = 1'b0;
	localparam logic              KIND_QUERY = 1'b1;

	typedef struct packed {
		logic clr_en;
		logic load;
		logic row_init;
		logic col_init;
		logic rd;
		logic upd;
		logic step_i;
		logic next_corner;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_add;
		logic add_ok;
		logic empty;
		logic i_done;
		logic j_done;
		logic last_corner;
		logic out_full;
	} stat_t;

endpackage

>>> rtl/core/rspu_op_if.sv
interface rspu_op_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    kind;
	logic        [rspu_pkg::COORD_W-1:0]     x_low;
	logic        [rspu_pkg::COORD_W-1:0]     y_low;
	logic        [rspu_pkg::COORD_W-1:0]     x_high;
	logic        [rspu_pkg::COORD_W-1:0]     y_high;
	logic signed [rspu_pkg::AMOUNT_W-1:0]    amount;

	modport source (output valid, kind, x_low, y_low, x_high, y_high, amount, input ready);
	modport sink   (input valid, kind, x_low, y_low, x_high, y_high, amount, output ready);
endinterface

>>> rtl/core/rspu_res_if.sv
interface rspu_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rspu_pkg::SUM_W-1:0]    rect_sum;

	modport source (output valid, rect_sum, input ready);
	modport sink   (input valid, rect_sum, output ready);
endinterface

>>> rtl/core/rectangle_sum_point_update.sv
// Channel   Direction  Interface    Payload
// op        in         rspu_op_if   kind, x_low, y_low, x_high, y_high, amount
// res       out        rspu_res_if  rect_sum
// cfg       in         cfg_we       cfg_wdata (grid_size)
//
// After reset the tree memory is cleared one word a cycle, all 2^(2*ceil(log2 GRID))
// words (65536 at the default size), and no request is taken until it ends.
// Each tree cell visited is read through the single memory port and then
// written back (add) or accumulated (query); an add walks the tree once and a
// query once for each of the four corners of its rectangle.
// One request is worked at a time; a finished sum waits in the output register.
module rectangle_sum_point_update #(
	parameter int GRID = rspu_pkg::GRID_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rspu_pkg::SIZE_W-1:0]   cfg_wdata,
	rspu_op_if.sink                       op,
	rspu_res_if.source                    res
);

	rspu_pkg::cmd_t  cmd;
	rspu_pkg::stat_t stat;

	rspu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op.valid),
		.op_ready (op.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rspu_dp #(
		.GRID (GRID)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_kind      (op.kind),
		.in_x_low     (op.x_low),
		.in_y_low     (op.y_low),
		.in_x_high    (op.x_high),
		.in_y_high    (op.y_high),
		.in_amount    (op.amount),
		.out_ready    (res.ready),
		.out_valid    (res.valid),
		.out_rect_sum (res.rect_sum),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

>>> rtl/core/rspu_ctrl.sv
module rspu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_ready,
	input  rspu_pkg::stat_t stat,
	output rspu_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_CORNER = 3'd3;
	localparam logic [2:0] ST_ROW    = 3'd4;
	localparam logic [2:0] ST_COL    = 3'd5;
	localparam logic [2:0] ST_UPD    = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign op_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (op_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				priority if (stat.is_add && !stat.add_ok) begin
					state_d = ST_IDLE;
				end else if (!stat.is_add && stat.empty) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_CORNER;
				end
			end
			ST_CORNER: begin
				cmd.row_init = 1'b1;
				state_d      = ST_ROW;
			end
			ST_ROW: begin
				priority if (!stat.i_done) begin
					cmd.col_init = 1'b1;
					state_d      = ST_COL;
				end else if (stat.is_add) begin
					state_d = ST_IDLE;
				end else if (stat.last_corner) begin
					state_d = ST_EMIT;
				end else begin
					cmd.next_corner = 1'b1;
					state_d         = ST_CORNER;
				end
			end
			ST_COL: begin
				if (stat.j_done) begin
					cmd.step_i = 1'b1;
					state_d    = ST_ROW;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_COL;
			end
			ST_EMIT: begin
				if (!stat.out_full) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/rspu_dp.sv
module rspu_dp #(
	parameter int GRID = rspu_pkg::GRID_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rspu_pkg::SIZE_W-1:0]        cfg_wdata,
	input  logic                               in_kind,
	input  logic [rspu_pkg::COORD_W-1:0]       in_x_low,
	input  logic [rspu_pkg::COORD_W-1:0]       in_y_low,
	input  logic [rspu_pkg::COORD_W-1:0]       in_x_high,
	input  logic [rspu_pkg::COORD_W-1:0]       in_y_high,
	input  logic signed [rspu_pkg::AMOUNT_W-1:0] in_amount,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [rspu_pkg::SUM_W-1:0]  out_rect_sum,
	input  rspu_pkg::cmd_t                     cmd,
	output rspu_pkg::stat_t                    stat
);

	localparam int IW    = $clog2(GRID);
	localparam int AW    = 2 * IW;
	localparam int CW    = IW + 2;
	localparam int KW    = (CW > rspu_pkg::COORD_W) ? CW : rspu_pkg::COORD_W;
	localparam int DEPTH = 1 << AW;

	localparam logic [KW-1:0] GRID_K = KW'(GRID);
	localparam logic [KW-1:0] ONE_K  = KW'(1);

	logic [rspu_pkg::SUM_W-1:0]     mem [DEPTH];

	logic [rspu_pkg::SIZE_W-1:0]    grid_size_q;
	logic                           kind_q;
	logic [rspu_pkg::COORD_W-1:0]   xl_q, yl_q, xh_q, yh_q;
	logic [rspu_pkg::SUM_W-1:0]     amount_q;
	logic [1:0]                     corner_q;
	logic [KW-1:0]                  i_q, j_q;
	logic [rspu_pkg::SUM_W-1:0]     acc_q;
	logic [rspu_pkg::SUM_W-1:0]     rdata_q;
	logic [AW-1:0]                  clr_q;
	logic                           out_valid_q;
	logic [rspu_pkg::SUM_W-1:0]     out_sum_q;

	logic [KW-1:0] size_k, s_eff;
	logic [KW-1:0] xl_k, yl_k, xh_k, yh_k;
	logic [KW-1:0] qxl, qyl, qxh, qyh;
	logic [KW-1:0] cx, cy;
	logic          neg;
	logic [KW-1:0] i_m1, j_m1;
	logic [AW-1:0] addr;
	logic [KW-1:0] i_next, j_next;

	assign size_k = KW'(grid_size_q);
	assign xl_k   = KW'(xl_q);
	assign yl_k   = KW'(yl_q);
	assign xh_k   = KW'(xh_q);
	assign yh_k   = KW'(yh_q);

	always_comb begin
		priority if (size_k == '0) begin
			s_eff = ONE_K;
		end else if (size_k > GRID_K) begin
			s_eff = GRID_K;
		end else begin
			s_eff = size_k;
		end
	end

	assign qxl = (xl_k == '0) ? ONE_K : xl_k;
	assign qyl = (yl_k == '0) ? ONE_K : yl_k;
	assign qxh = (xh_k > s_eff) ? s_eff : xh_k;
	assign qyh = (yh_k > s_eff) ? s_eff : yh_k;

	always_comb begin
		unique case (corner_q)
			2'd0: begin
				cx = qxh;
				cy = qyh;
			end
			2'd1: begin
				cx = qxl - ONE_K;
				cy = qyh;
			end
			2'd2: begin
				cx = qxh;
				cy = qyl - ONE_K;
			end
			2'd3: begin
				cx = qxl - ONE_K;
				cy = qyl - ONE_K;
			end
		endcase
	end

	assign neg = (corner_q == 2'd1) || (corner_q == 2'd2);

	assign i_m1 = i_q - ONE_K;
	assign j_m1 = j_q - ONE_K;
	assign addr = {i_m1[IW-1:0], j_m1[IW-1:0]};

	assign i_next = kind_q ? (i_q & i_m1) : (i_q + (i_q & (~i_q + ONE_K)));
	assign j_next = kind_q ? (j_q & j_m1) : (j_q + (j_q & (~j_q + ONE_K)));

	assign stat.clr_done    = (clr_q == {AW{1'b1}});
	assign stat.is_add      = (kind_q == rspu_pkg::KIND_ADD);
	assign stat.add_ok      = (xl_k != '0) && (xl_k <= s_eff) && (yl_k != '0) && (yl_k <= s_eff);
	assign stat.empty       = (qxl > qxh) || (qyl > qyh);
	assign stat.i_done      = (i_q == '0) || (i_q > GRID_K);
	assign stat.j_done      = (j_q == '0) || (j_q > GRID_K);
	assign stat.last_corner = (corner_q == 2'd3);
	assign stat.out_full    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= rspu_pkg::SIZE_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				grid_size_q <= cfg_wdata;
			end
			if (cmd.clr_en) begin
				clr_q <= clr_q + AW'(1);
			end
			priority if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			xl_q     <= in_x_low;
			yl_q     <= in_y_low;
			xh_q     <= in_x_high;
			yh_q     <= in_y_high;
			amount_q <= in_amount;
			corner_q <= 2'd0;
			acc_q    <= '0;
		end
		if (cmd.next_corner) begin
			corner_q <= corner_q + 2'd1;
		end
		if (cmd.row_init) begin
			i_q <= stat.is_add ? xl_k : cx;
		end
		if (cmd.step_i) begin
			i_q <= i_next;
		end
		if (cmd.col_init) begin
			j_q <= stat.is_add ? yl_k : cy;
		end
		if (cmd.upd) begin
			j_q <= j_next;
			if (!stat.is_add) begin
				acc_q <= neg ? (acc_q - rdata_q) : (acc_q + rdata_q);
			end
		end
		if (cmd.emit) begin
			out_sum_q <= acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			mem[clr_q] <= '0;
		end else if (cmd.upd && stat.is_add) begin
			mem[addr] <= rdata_q + amount_q;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_rect_sum = out_sum_q;

endmodule
